/* rtl/core/ukvt_pkg.sv */
`timescale 1ns / 1ps

package ukvt_pkg;

  localparam int DefDepth      = 16;
  localparam int DefKeyWidth   = 32;
  localparam int DefValueWidth = 32;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_LIST   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_ADDED   = 3'd0,
    ST_DUP     = 3'd1,
    ST_FOUND   = 3'd2,
    ST_MISSING = 3'd3,
    ST_REMOVED = 3'd4,
    ST_LISTED  = 3'd5,
    ST_EMPTY   = 3'd6,
    ST_FULL    = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2,
    CELL_ROTATE = 2'd3
  } cell_op_t;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_LIST = 1'b1
  } fsm_t;

endpackage

/* rtl/core/unique_key_value_table.sv */
// Insert, lookup and remove each return one result through the output register; the
// next item is taken in the following cycle if the output register is free.
// A list of N entries starts when accepted and then gives N results, as the cell
// row rotates one entry into the output register each cycle that register is free.
// Synchronous reset empties the table; entry contents are not cleared.
`timescale 1ns / 1ps

module unique_key_value_table #(
  parameter int DEPTH       = ukvt_pkg::DefDepth,
  parameter int KEY_WIDTH   = ukvt_pkg::DefKeyWidth,
  parameter int VALUE_WIDTH = ukvt_pkg::DefValueWidth
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             kind,
  input  logic [KEY_WIDTH-1:0]   key,
  input  logic [VALUE_WIDTH-1:0] value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output ukvt_pkg::status_t      status,
  output logic [KEY_WIDTH-1:0]   out_key,
  output logic [VALUE_WIDTH-1:0] out_value,
  output logic                   last
);
  import ukvt_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] Full = CNT_W'(DEPTH);

  fsm_t             state;
  fsm_t             state_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W-1:0] remain;
  logic [CNT_W-1:0] remain_next;

  logic    out_free;
  logic    accept;
  kind_t   kind_in;
  logic    emit;
  status_t emit_status;
  logic    emit_use_found;
  logic    emit_use_head;
  logic    emit_last;
  cell_op_t cell_op;

  logic [KEY_WIDTH-1:0]   cell_key   [DEPTH];
  logic [VALUE_WIDTH-1:0] cell_value [DEPTH];
  logic [KEY_WIDTH-1:0]   nkey       [DEPTH];
  logic [VALUE_WIDTH-1:0] nvalue     [DEPTH];
  logic                   hit        [DEPTH+1];
  logic [KEY_WIDTH-1:0]   fkey       [DEPTH+1];
  logic [VALUE_WIDTH-1:0] fvalue     [DEPTH+1];
  logic                   any_hit;

  assign hit[0]    = 1'b0;
  assign fkey[0]   = '0;
  assign fvalue[0] = '0;
  assign any_hit   = hit[DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == DEPTH - 1) begin : g_tail
      assign nkey[i]   = '0;
      assign nvalue[i] = '0;
    end else begin : g_mid
      assign nkey[i]   = cell_key[i+1];
      assign nvalue[i] = cell_value[i+1];
    end

    ukvt_cell #(
      .IDX         (i),
      .CNT_W       (CNT_W),
      .KEY_WIDTH   (KEY_WIDTH),
      .VALUE_WIDTH (VALUE_WIDTH)
    ) u_cell (
      .clk             (clk),
      .op              (cell_op),
      .count           (count),
      .in_key          (key),
      .in_value        (value),
      .wrap_key        (cell_key[0]),
      .wrap_value      (cell_value[0]),
      .next_key        (nkey[i]),
      .next_value      (nvalue[i]),
      .hit_in          (hit[i]),
      .found_key_in    (fkey[i]),
      .found_value_in  (fvalue[i]),
      .key_q           (cell_key[i]),
      .value_q         (cell_value[i]),
      .hit_out         (hit[i+1]),
      .found_key_out   (fkey[i+1]),
      .found_value_out (fvalue[i+1])
    );
  end

  assign out_free = ~out_valid | ~out_stall;
  assign in_stall = (state != FSM_IDLE) | ~out_free;
  assign accept   = in_valid & ~in_stall;
  assign kind_in  = kind_t'(kind);

  always_comb begin
    state_next = state;
    unique case (state)
      FSM_IDLE: begin
        if (accept && kind_in == KIND_LIST && count != '0) begin
          state_next = FSM_LIST;
        end
      end
      FSM_LIST: begin
        if (out_free && remain == CNT_W'(1)) begin
          state_next = FSM_IDLE;
        end
      end
      default: state_next = FSM_IDLE;
    endcase
  end

  always_comb begin
    emit           = 1'b0;
    emit_status    = ST_ADDED;
    emit_use_found = 1'b0;
    emit_use_head  = 1'b0;
    emit_last      = 1'b1;
    cell_op        = CELL_HOLD;
    count_next     = count;
    remain_next    = remain;
    unique case (state)
      FSM_IDLE: begin
        if (accept) begin
          emit = 1'b1;
          unique case (kind_in)
            KIND_INSERT: begin
              if (any_hit) begin
                emit_status = ST_DUP;
              end else if (count == Full) begin
                emit_status = ST_FULL;
              end else begin
                emit_status = ST_ADDED;
                cell_op     = CELL_INSERT;
                count_next  = count + CNT_W'(1);
              end
            end
            KIND_LOOKUP: begin
              emit_status    = any_hit ? ST_FOUND : ST_MISSING;
              emit_use_found = any_hit;
            end
            KIND_REMOVE: begin
              if (any_hit) begin
                emit_status = ST_REMOVED;
                cell_op     = CELL_REMOVE;
                count_next  = count - CNT_W'(1);
              end else begin
                emit_status = ST_MISSING;
              end
            end
            KIND_LIST: begin
              if (count == '0) begin
                emit_status = ST_EMPTY;
              end else begin
                emit        = 1'b0;
                remain_next = count;
              end
            end
            default: begin
            end
          endcase
        end
      end
      FSM_LIST: begin
        if (out_free) begin
          emit          = 1'b1;
          emit_status   = ST_LISTED;
          emit_use_head = 1'b1;
          emit_last     = (remain == CNT_W'(1));
          cell_op       = CELL_ROTATE;
          remain_next   = remain - CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= FSM_IDLE;
      count     <= '0;
      remain    <= '0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      remain <= remain_next;
      if (out_free) begin
        out_valid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      status <= emit_status;
      last   <= emit_last;
      if (emit_use_head) begin
        out_key   <= cell_key[0];
        out_value <= cell_value[0];
      end else if (emit_use_found) begin
        out_key   <= fkey[DEPTH];
        out_value <= fvalue[DEPTH];
      end else begin
        out_key   <= '0;
        out_value <= '0;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= Full)
    else $error("entry count exceeds table depth");

  a_no_accept_in_list: assert property (@(posedge clk) disable iff (rst)
    state == FSM_LIST |-> !accept)
    else $error("input transfer taken during a list");

  a_list_ends: assert property (@(posedge clk) disable iff (rst)
    (state == FSM_LIST && out_free && remain == CNT_W'(1)) |=>
      (state == FSM_IDLE && out_valid && last))
    else $error("list did not end with a last result");

  a_add_grows: assert property (@(posedge clk) disable iff (rst)
    (emit && emit_status == ST_ADDED) |=> count == $past(count) + CNT_W'(1))
    else $error("insert did not grow the table");

  a_remove_shrinks: assert property (@(posedge clk) disable iff (rst)
    (emit && emit_status == ST_REMOVED) |=> count == $past(count) - CNT_W'(1))
    else $error("remove did not shrink the table");

endmodule

/* rtl/core/ukvt_cell.sv */
`timescale 1ns / 1ps

module ukvt_cell #(
  parameter int IDX         = 0,
  parameter int CNT_W       = 5,
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  ukvt_pkg::cell_op_t     op,
  input  logic [CNT_W-1:0]       count,
  input  logic [KEY_WIDTH-1:0]   in_key,
  input  logic [VALUE_WIDTH-1:0] in_value,
  input  logic [KEY_WIDTH-1:0]   wrap_key,
  input  logic [VALUE_WIDTH-1:0] wrap_value,
  input  logic [KEY_WIDTH-1:0]   next_key,
  input  logic [VALUE_WIDTH-1:0] next_value,
  input  logic                   hit_in,
  input  logic [KEY_WIDTH-1:0]   found_key_in,
  input  logic [VALUE_WIDTH-1:0] found_value_in,
  output logic [KEY_WIDTH-1:0]   key_q,
  output logic [VALUE_WIDTH-1:0] value_q,
  output logic                   hit_out,
  output logic [KEY_WIDTH-1:0]   found_key_out,
  output logic [VALUE_WIDTH-1:0] found_value_out
);
  import ukvt_pkg::*;

  localparam logic [CNT_W-1:0] MyIdx = CNT_W'(IDX);

  logic                   occupied;
  logic                   match;
  logic                   first;
  logic [KEY_WIDTH-1:0]   key_next;
  logic [VALUE_WIDTH-1:0] value_next;

  always_comb begin
    occupied        = (MyIdx < count);
    match           = occupied && (key_q == in_key);
    hit_out         = hit_in | match;
    first           = match & ~hit_in;
    found_key_out   = found_key_in | ({KEY_WIDTH{first}} & key_q);
    found_value_out = found_value_in | ({VALUE_WIDTH{first}} & value_q);
  end

  // A removal pulls every entry from the first match onward down by one.
  always_comb begin
    key_next   = key_q;
    value_next = value_q;
    unique case (op)
      CELL_HOLD: begin
      end
      CELL_INSERT: begin
        if (MyIdx == count) begin
          key_next   = in_key;
          value_next = in_value;
        end
      end
      CELL_REMOVE: begin
        if (hit_out) begin
          key_next   = next_key;
          value_next = next_value;
        end
      end
      CELL_ROTATE: begin
        if (MyIdx == count - CNT_W'(1)) begin
          key_next   = wrap_key;
          value_next = wrap_value;
        end else begin
          key_next   = next_key;
          value_next = next_value;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    key_q   <= key_next;
    value_q <= value_next;
  end

endmodule

/* sim/tb_unique_key_value_table.sv */
`timescale 1ns / 1ps

module tb_unique_key_value_table;
  import ukvt_pkg::*;

  localparam int Depth = 16;
  localparam int KeyPool = 20;

  typedef struct {
    status_t     status;
    logic [31:0] key;
    logic [31:0] value;
    logic        last;
  } table_result_t;

  class table_scoreboard;
    logic [31:0]   entry_key[Depth];
    logic [31:0]   entry_value[Depth];
    int            entry_count;
    table_result_t pending_results[$];
    int            error_count;
    int            op_count[4];
    int            result_count;
    int            full_refusals;
    int            empty_lists;

    function new();
      entry_count = 0;
      error_count = 0;
      result_count = 0;
      full_refusals = 0;
      empty_lists = 0;
      foreach (op_count[i]) op_count[i] = 0;
    endfunction

    function int find_entry(logic [31:0] k);
      for (int i = 0; i < entry_count; i++) begin
        if (entry_key[i] == k) return i;
      end
      return entry_count;
    endfunction

    function void add_expected(status_t st, logic [31:0] k, logic [31:0] v, logic l);
      table_result_t r;
      r.status = st;
      r.key = k;
      r.value = v;
      r.last = l;
      pending_results.insert(pending_results.size(), r);
    endfunction

    function void note_transfer(kind_t op, logic [31:0] k, logic [31:0] v);
      int pos;
      pos = find_entry(k);
      op_count[op]++;
      case (op)
        KIND_INSERT: begin
          if (pos < entry_count) begin
            add_expected(ST_DUP, '0, '0, 1'b1);
          end else if (entry_count >= Depth) begin
            add_expected(ST_FULL, '0, '0, 1'b1);
            full_refusals++;
          end else begin
            entry_key[entry_count] = k;
            entry_value[entry_count] = v;
            entry_count++;
            add_expected(ST_ADDED, '0, '0, 1'b1);
          end
        end
        KIND_LOOKUP: begin
          if (pos < entry_count) begin
            add_expected(ST_FOUND, entry_key[pos], entry_value[pos], 1'b1);
          end else begin
            add_expected(ST_MISSING, '0, '0, 1'b1);
          end
        end
        KIND_REMOVE: begin
          if (pos < entry_count) begin
            for (int i = pos; i + 1 < entry_count; i++) begin
              entry_key[i] = entry_key[i + 1];
              entry_value[i] = entry_value[i + 1];
            end
            entry_count--;
            add_expected(ST_REMOVED, '0, '0, 1'b1);
          end else begin
            add_expected(ST_MISSING, '0, '0, 1'b1);
          end
        end
        default: begin
          if (entry_count == 0) begin
            add_expected(ST_EMPTY, '0, '0, 1'b1);
            empty_lists++;
          end else begin
            for (int i = 0; i < entry_count; i++) begin
              add_expected(ST_LISTED, entry_key[i], entry_value[i], i + 1 == entry_count);
            end
          end
        end
      endcase
    endfunction

    function int field_differs(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        return 1;
      end
      return 0;
    endfunction

    function void check_transfer(status_t st, logic [31:0] k, logic [31:0] v, logic l);
      table_result_t want;
      result_count++;
      if (pending_results.size() == 0) begin
        $display({"%0t: unexpected result, expected none, ",
                  "actual status %0d key %h value %h last %b"},
                 $time, st, k, v, l);
        error_count++;
        return;
      end
      want = pending_results.pop_front();
      error_count += field_differs("status", 32'(want.status), 32'(st));
      error_count += field_differs("out_key", want.key, k);
      error_count += field_differs("out_value", want.value, v);
      error_count += field_differs("last", 32'(want.last), 32'(l));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  kind = 2'd0;
  logic [31:0] key = '0;
  logic [31:0] value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  status_t     status;
  logic [31:0] out_key;
  logic [31:0] out_value;
  logic        last;

  table_scoreboard sb = new();
  int          send_idle_pct = 19;
  int          recv_stall_pct = 85;
  logic [31:0] key_pool[KeyPool];

  unique_key_value_table i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .key       (key),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .out_key   (out_key),
    .out_value (out_value),
    .last      (last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      sb.check_transfer(status, out_key, out_value, last);
    end
    out_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
  end

  task automatic send_op(kind_t op, logic [31:0] k, logic [31:0] v);
    while ((send_idle_pct > 0) && ($urandom_range(99) < send_idle_pct)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= op;
    key <= k;
    value <= v;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_transfer(op, k, v);
  endtask

  task automatic run_directed();
    send_op(KIND_LIST, 32'h0, 32'h0);
    send_op(KIND_LOOKUP, 32'h0, 32'h0);
    send_op(KIND_REMOVE, 32'h0, 32'hFFFF_FFFF);
    send_op(KIND_INSERT, 32'h0, 32'hFFFF_FFFF);
    send_op(KIND_INSERT, 32'hFFFF_FFFF, 32'h0);
    send_op(KIND_INSERT, 32'h0, 32'h1234_5678);
    send_op(KIND_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(KIND_LIST, 32'h0, 32'h0);
    for (int i = 0; i < Depth - 2; i++) begin
      send_op(KIND_INSERT, 32'h1000 + i, $urandom);
    end
    send_op(KIND_INSERT, 32'hDEAD_BEEF, 32'h5555_AAAA);
    send_op(KIND_INSERT, 32'hFFFF_FFFF, 32'hAAAA_5555);
    send_op(KIND_LIST, 32'h0, 32'h0);
    send_op(KIND_REMOVE, 32'h0, 32'h0);
    send_op(KIND_REMOVE, 32'h1000 + Depth - 3, 32'h0);
    send_op(KIND_LIST, 32'h0, 32'h0);
  endtask

  task automatic run_random(int count);
    int    roll;
    logic  filling;
    kind_t op;
    logic [31:0] k;
    filling = 1'b1;
    for (int n = 0; n < count; n++) begin
      if (n % 30 == 29) filling = !filling;
      roll = $urandom_range(99);
      if (filling) begin
        op = (roll < 55) ? KIND_INSERT : (roll < 75) ? KIND_LOOKUP :
             (roll < 88) ? KIND_REMOVE : KIND_LIST;
      end else begin
        op = (roll < 20) ? KIND_INSERT : (roll < 40) ? KIND_LOOKUP :
             (roll < 85) ? KIND_REMOVE : KIND_LIST;
      end
      k = ($urandom_range(99) < 85) ? key_pool[$urandom_range(KeyPool - 1)] : $urandom;
      send_op(op, k, $urandom);
    end
  endtask

  initial begin
    int wait_cycles;
    key_pool[0] = 32'h0;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < KeyPool; i++) key_pool[i] = $urandom;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    run_random(100);
    send_idle_pct = 85;
    recv_stall_pct = 19;
    run_random(100);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_random(100);
    in_valid <= 1'b0;
    wait_cycles = 0;
    while (sb.pending_results.size() > 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (32) @(posedge clk);
    if (sb.pending_results.size() > 0) begin
      $display("%0t: %0d expected results never arrived, first expected status %0d",
               $time, sb.pending_results.size(), sb.pending_results[0].status);
      sb.error_count++;
    end
    $display("Covered %0d input transfers (%0d insert, %0d lookup, %0d remove, %0d list).",
             sb.op_count[0] + sb.op_count[1] + sb.op_count[2] + sb.op_count[3],
             sb.op_count[0], sb.op_count[1], sb.op_count[2], sb.op_count[3]);
    $display("Checked %0d result transfers; full table refusals %0d, empty lists %0d.",
             sb.result_count, sb.full_refusals, sb.empty_lists);
    if (sb.error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d results still expected.", sb.pending_results.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/ukvt_pkg.sv
rtl/core/ukvt_cell.sv
rtl/core/unique_key_value_table.sv
sim/tb_unique_key_value_table.sv
